/* hdl/csv_pkg.sv */
// Shared types and constants of the cube sphere face vertex generator.
package csv_pkg;

	localparam int QW = 16;
	localparam int FRAC_SHIFT = 30;

	typedef struct packed {
		logic [13:0] vertex_index;
		logic        quad_valid;
		logic [16:0] index_slot;
		logic [13:0] tri0_a;
		logic [13:0] tri0_b;
		logic [13:0] tri0_c;
		logic [13:0] tri1_a;
		logic [13:0] tri1_b;
		logic [13:0] tri1_c;
		logic        neg_x;
		logic        neg_z;
	} side_t;

endpackage

/* hdl/csv_norm_lane.sv */
// Pipelined bit-serial evaluation of floor(32768 * c / sqrt(s)) for one coordinate.
module csv_norm_lane #(
	parameter int DW = 7
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2*DW-1:0]       csq,
	input  logic [2*DW+1:0]       s,
	output logic [csv_pkg::QW-1:0] q
);
	import csv_pkg::*;

	localparam int SW = 2 * DW + 2;
	localparam int RW = 2 * DW + FRAC_SHIFT;
	localparam int TW = SW + 2 * QW + 1;

	logic [RW-1:0]    r_s  [QW+1];
	logic [SW-1:0]    s_s  [QW+1];
	logic [SW+QW-1:0] sq_s [QW+1];
	logic [QW-1:0]    q_s  [QW+1];
	logic [TW-1:0]    trial [QW];
	logic             fits  [QW];

	always_comb begin
		for (int i = 0; i < QW; i++) begin
			trial[i] = (TW'(sq_s[i]) << (QW - i)) + (TW'(s_s[i]) << (2 * (QW - 1 - i)));
			fits[i]  = trial[i] <= TW'(r_s[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]  <= RW'(csq) << FRAC_SHIFT;
			s_s[0]  <= s;
			sq_s[0] <= '0;
			q_s[0]  <= '0;
			for (int i = 0; i < QW; i++) begin
				s_s[i+1] <= s_s[i];
				if (fits[i]) begin
					r_s[i+1]  <= RW'(TW'(r_s[i]) - trial[i]);
					sq_s[i+1] <= sq_s[i] + ((SW + QW)'(s_s[i]) << (QW - 1 - i));
					q_s[i+1]  <= q_s[i] | (QW'(1) << (QW - 1 - i));
				end else begin
					r_s[i+1]  <= r_s[i];
					sq_s[i+1] <= sq_s[i];
					q_s[i+1]  <= q_s[i];
				end
			end
		end
	end

	assign q = q_s[QW];

endmodule

/* hdl/cube_sphere_face_vertex_gen_core.sv */
// Top level of the cube sphere face vertex generator.
// One word is accepted per cycle while the output is not stalled.
// Most of the pipeline depth comes from the sixteen-step bit-serial normalization pipeline in each lane.
// A stall at the output holds every stage; nothing is lost or repeated.
// Reset clears the valid bits and sets grid_size to 3.
module cube_sphere_face_vertex_gen_core #(
	parameter int MAX_GRID = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [6:0]         grid_x,
	input  logic [6:0]         grid_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] pos_x,
	output logic [14:0]        pos_y,
	output logic signed [15:0] pos_z,
	output logic [13:0]        vertex_index,
	output logic               quad_valid,
	output logic [16:0]        index_slot,
	output logic [13:0]        tri0_a,
	output logic [13:0]        tri0_b,
	output logic [13:0]        tri0_c,
	output logic [13:0]        tri1_a,
	output logic [13:0]        tri1_b,
	output logic [13:0]        tri1_c
);
	import csv_pkg::*;

	localparam int DW = $clog2(MAX_GRID);
	localparam int NW = $clog2(MAX_GRID + 1);
	localparam int VW = DW + NW + 1;
	localparam int LD = QW + 1;
	localparam int NST = 3 + LD + 1;

	logic [7:0]     grid_size_q;
	logic [NST-1:0] vld_q;
	logic           en;

	assign en        = !vld_q[NST-1] || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= 8'd3;
		end else if (cfg_valid) begin
			grid_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	logic [8:0]    gs9;
	logic [NW-1:0] n_c;
	logic [DW-1:0] d_c;
	logic [DW-1:0] x_c;
	logic [DW-1:0] y_c;

	always_comb begin
		gs9 = {1'b0, grid_size_q};
		if (gs9 < 9'd3) begin
			n_c = NW'(3);
		end else if (gs9 > 9'(MAX_GRID)) begin
			n_c = NW'(MAX_GRID);
		end else begin
			n_c = NW'(gs9);
		end
		d_c = DW'(n_c - NW'(1));
		x_c = ({2'b0, grid_x} > 9'(d_c)) ? d_c : DW'(grid_x);
		y_c = ({2'b0, grid_y} > 9'(d_c)) ? d_c : DW'(grid_y);
	end

	logic [DW-1:0] x_s1, y_s1, d_s1;
	logic [NW-1:0] n_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_c;
			y_s1 <= y_c;
			d_s1 <= d_c;
			n_s1 <= n_c;
		end
	end

	logic [DW:0]     x2, y2;
	logic [DW-1:0]   ma_s2, mb_s2, d_s2, x_s2;
	logic            na_s2, nb_s2, cell_s2;
	logic [NW-1:0]   n_s2;
	logic [DW+NW-1:0] yn_s2;
	logic [2*DW:0]   yd_s2;

	assign x2 = {x_s1, 1'b0};
	assign y2 = {y_s1, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			na_s2   <= x2 < (DW + 1)'(d_s1);
			nb_s2   <= y2 < (DW + 1)'(d_s1);
			ma_s2   <= (x2 < (DW + 1)'(d_s1)) ? DW'((DW + 1)'(d_s1) - x2)
				: DW'(x2 - (DW + 1)'(d_s1));
			mb_s2   <= (y2 < (DW + 1)'(d_s1)) ? DW'((DW + 1)'(d_s1) - y2)
				: DW'(y2 - (DW + 1)'(d_s1));
			d_s2    <= d_s1;
			x_s2    <= x_s1;
			n_s2    <= n_s1;
			cell_s2 <= (x_s1 < d_s1) && (y_s1 < d_s1);
			yn_s2   <= (DW + NW)'(y_s1) * (DW + NW)'(n_s1);
			yd_s2   <= (2 * DW + 1)'((2 * DW + 1)'(y_s1) * (2 * DW + 1)'(d_s1))
				+ (2 * DW + 1)'(x_s1);
		end
	end

	logic [VW-1:0]     v_c;
	logic [2*DW+3:0]   slot_c;
	logic [2*DW-1:0]   sqa_s3, sqb_s3, sqd_s3;
	side_t             side_s3;
	side_t             side_c;

	always_comb begin
		v_c    = VW'(yn_s2) + VW'(x_s2);
		slot_c = ((2 * DW + 4)'(yd_s2) << 2) + ((2 * DW + 4)'(yd_s2) << 1);
		side_c.vertex_index = 14'(v_c);
		side_c.quad_valid   = cell_s2;
		side_c.neg_x        = na_s2;
		side_c.neg_z        = nb_s2;
		if (cell_s2) begin
			side_c.index_slot = 17'(slot_c);
			side_c.tri0_a     = 14'(v_c);
			side_c.tri0_b     = 14'(v_c + VW'(n_s2));
			side_c.tri0_c     = 14'(v_c + VW'(n_s2) + VW'(1));
			side_c.tri1_a     = 14'(v_c);
			side_c.tri1_b     = 14'(v_c + VW'(n_s2) + VW'(1));
			side_c.tri1_c     = 14'(v_c + VW'(1));
		end else begin
			side_c.index_slot = '0;
			side_c.tri0_a     = '0;
			side_c.tri0_b     = '0;
			side_c.tri0_c     = '0;
			side_c.tri1_a     = '0;
			side_c.tri1_b     = '0;
			side_c.tri1_c     = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s3  <= (2 * DW)'(ma_s2) * (2 * DW)'(ma_s2);
			sqb_s3  <= (2 * DW)'(mb_s2) * (2 * DW)'(mb_s2);
			sqd_s3  <= (2 * DW)'(d_s2) * (2 * DW)'(d_s2);
			side_s3 <= side_c;
		end
	end

	logic [2*DW+1:0] s_c;
	assign s_c = (2 * DW + 2)'(sqa_s3) + (2 * DW + 2)'(sqb_s3) + (2 * DW + 2)'(sqd_s3);

	logic [QW-1:0] qx, qy, qz;

	csv_norm_lane #(.DW(DW)) u_lane_x (
		.clk(clk), .en(en), .csq(sqa_s3), .s(s_c), .q(qx)
	);
	csv_norm_lane #(.DW(DW)) u_lane_y (
		.clk(clk), .en(en), .csq(sqd_s3), .s(s_c), .q(qy)
	);
	csv_norm_lane #(.DW(DW)) u_lane_z (
		.clk(clk), .en(en), .csq(sqb_s3), .s(s_c), .q(qz)
	);

	side_t side_q [LD];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s3;
			for (int i = 1; i < LD; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	logic [14:0] mx, my, mz;
	side_t       side_o;

	assign mx     = 15'(({1'b0, qx} + 17'd1) >> 1);
	assign my     = 15'(({1'b0, qy} + 17'd1) >> 1);
	assign mz     = 15'(({1'b0, qz} + 17'd1) >> 1);
	assign side_o = side_q[LD-1];

	side_t side_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_x    <= side_o.neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
			pos_y    <= my;
			pos_z    <= side_o.neg_z ? -$signed({1'b0, mz}) : $signed({1'b0, mz});
			side_s21 <= side_o;
		end
	end

	assign vertex_index = side_s21.vertex_index;
	assign quad_valid   = side_s21.quad_valid;
	assign index_slot   = side_s21.index_slot;
	assign tri0_a       = side_s21.tri0_a;
	assign tri0_b       = side_s21.tri0_b;
	assign tri0_c       = side_s21.tri0_c;
	assign tri1_a       = side_s21.tri1_a;
	assign tri1_b       = side_s21.tri1_b;
	assign tri1_c       = side_s21.tri1_c;

endmodule
